/* rtl/text_line_justifier_defines.svh */
// Assertion macros for the text line justifier
`ifndef TEXT_LINE_JUSTIFIER_DEFINES_SVH
`define TEXT_LINE_JUSTIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TLJ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TLJ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tlj_pkg.sv */
// Shared types, constants and helpers of the text line justifier
`default_nettype none
package tlj_pkg;
	localparam int MAX_LINE_DEF = 31;
	localparam int MAX_RESULTS = 64;
	localparam int RCW = $clog2(MAX_RESULTS + 1);
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] WIDTH_RST = 5'd31;

	localparam logic OP_TEXT = 1'b0;
	localparam logic OP_EOT = 1'b1;

	localparam int CLS_W = 2;
	localparam logic [CLS_W-1:0] CLS_TEXT = 2'd0;
	localparam logic [CLS_W-1:0] CLS_SEP = 2'd1;
	localparam logic [CLS_W-1:0] CLS_EOT = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef struct packed {
		logic operation;
		logic [7:0] text_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic is_error;
		logic last;
	} out_t;

	typedef struct packed {
		logic valid;
		logic [CLS_W-1:0] cls;
		logic [7:0] ch;
	} head_t;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) || (c == CH_CR) ||
			(c == CH_VT) || (c == CH_FF);
	endfunction
endpackage
`default_nettype wire

/* rtl/tlj_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module tlj_ram #(
	parameter int W = 8,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [W-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/tlj_front.sv */
// Input side: accepts input bytes, classifies them and queues them for the sequencer
`default_nettype none
module tlj_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic src_valid,
	output logic src_ready,
	input wire tlj_pkg::in_t src_data,
	output tlj_pkg::head_t head,
	input wire logic pop
);
	logic [tlj_pkg::CLS_W-1:0] cls_q [2];
	logic [7:0] ch_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic [tlj_pkg::CLS_W-1:0] cls_in;
	logic push;

	always_comb begin
		if (src_data.operation == tlj_pkg::OP_EOT) begin
			cls_in = tlj_pkg::CLS_EOT;
		end else if (tlj_pkg::is_sep(src_data.text_byte)) begin
			cls_in = tlj_pkg::CLS_SEP;
		end else begin
			cls_in = tlj_pkg::CLS_TEXT;
		end
	end

	assign src_ready = (count_q != 2'd2);
	assign push = src_valid && src_ready;
	assign head.valid = (count_q != 2'd0);
	assign head.cls = cls_q[rd_ptr_q];
	assign head.ch = ch_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cls_q[wr_ptr_q] <= cls_in;
			ch_q[wr_ptr_q] <= src_data.text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

/* rtl/tlj_back.sv */
// Sequencer: word buffering, hyphen splitting, line packing and justified output
`default_nettype none
module tlj_back #(
	parameter int MAX_LINE = tlj_pkg::MAX_LINE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [tlj_pkg::CFG_W-1:0] line_width,
	input wire tlj_pkg::head_t head,
	output logic pop,
	output logic dst_valid,
	input wire logic dst_ready,
	output tlj_pkg::out_t dst_data
);
	localparam int WD = MAX_LINE + 1;
	localparam int WAW = $clog2(MAX_LINE + 1);
	localparam int WFW = $clog2(MAX_LINE + 2);
	localparam int LAW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_REDUCE = 5'd1;
	localparam logic [4:0] S_POST = 5'd2;
	localparam logic [4:0] S_TAIL = 5'd3;
	localparam logic [4:0] S_ADD = 5'd4;
	localparam logic [4:0] S_ADD_SP = 5'd5;
	localparam logic [4:0] S_CP_RD = 5'd6;
	localparam logic [4:0] S_CP_WR = 5'd7;
	localparam logic [4:0] S_FLUSH = 5'd8;
	localparam logic [4:0] S_DIV = 5'd9;
	localparam logic [4:0] S_LEFT = 5'd10;
	localparam logic [4:0] S_RD = 5'd11;
	localparam logic [4:0] S_USE = 5'd12;
	localparam logic [4:0] S_GAP = 5'd13;
	localparam logic [4:0] S_RIGHT = 5'd14;
	localparam logic [4:0] S_NL = 5'd15;
	localparam logic [4:0] S_ERR = 5'd16;
	localparam logic [4:0] S_DONE = 5'd17;

	localparam logic [1:0] K_OVER = 2'd0;
	localparam logic [1:0] K_ONE = 2'd1;
	localparam logic [1:0] K_MULTI = 2'd2;

	logic [4:0] state_q;
	logic [4:0] add_ret_q;
	logic [4:0] flush_ret_q;
	logic commit_q;
	logic eot_q;
	logic halted_q;
	logic [WAW-1:0] lfill_q;
	logic [WAW-1:0] lwc_q;
	logic [WFW-1:0] wfill_q;
	logic [WAW-1:0] wbase_q;
	logic [MAX_LINE:0] hyph_q;
	logic [WAW-1:0] src_q;
	logic [WAW-1:0] len_q;
	logic [WAW-1:0] k_q;
	logic [WAW-1:0] i_q;
	logic [1:0] kind_q;
	logic [WAW-1:0] r_q;
	logic [WAW-1:0] quo_q;
	logic [WAW-1:0] gaps_q;
	logic [WAW-1:0] per_q;
	logic [WAW-1:0] extra_q;
	logic [WAW-1:0] sp_q;
	logic [WAW-1:0] right_q;
	logic [tlj_pkg::RCW-1:0] res_cnt_q;
	logic pend_v_q;
	tlj_pkg::out_t pend_q;
	logic out_v_q;
	tlj_pkg::out_t out_q;

	logic [WAW-1:0] w_eff;
	logic [WAW-1:0] h;
	logic found;
	logic [WAW-1:0] hp1;
	logic fits;
	logic last_ch;
	logic capped;
	logic slot_free;
	logic emit_req;
	logic emit_ok;
	logic emit_fire;
	logic done_ok;
	tlj_pkg::out_t emit_val;
	logic [WAW-1:0] pad_one;
	logic [WAW:0] pad_one_up;
	logic [WAW-1:0] gaps_n;

	logic wwe;
	logic [WAW-1:0] wwaddr;
	logic [WAW-1:0] wraddr;
	logic [7:0] wrdata;
	logic lwe;
	logic [7:0] lwdata;
	logic [7:0] lrdata;

	function automatic logic [WAW-1:0] wrap(input logic [WAW-1:0] a, input logic [WAW-1:0] b);
		logic [WAW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (WAW+1)'(WD)) begin
			s = s - (WAW+1)'(WD);
		end
		return s[WAW-1:0];
	endfunction

	assign w_eff = (line_width > tlj_pkg::CFG_W'(MAX_LINE)) ? WAW'(MAX_LINE) : WAW'(line_width);

	always_comb begin
		h = '0;
		found = 1'b0;
		for (int j = 1; j <= MAX_LINE; j++) begin
			if (hyph_q[j] && (j < w_eff)) begin
				h = WAW'(j);
				found = 1'b1;
			end
		end
	end

	assign hp1 = h + WAW'(1);
	assign fits = ((WAW+2)'(lfill_q) + (WAW+2)'(lwc_q != '0) + (WAW+2)'(len_q))
		<= (WAW+2)'(w_eff);
	assign last_ch = ((WAW+1)'(i_q) + (WAW+1)'(1)) == (WAW+1)'(lfill_q);
	assign pad_one = w_eff - lfill_q;
	assign pad_one_up = (WAW+1)'(pad_one) + (WAW+1)'(1);
	assign gaps_n = lwc_q - WAW'(1);

	assign capped = (res_cnt_q >= tlj_pkg::RCW'(tlj_pkg::MAX_RESULTS));
	assign slot_free = !out_v_q || dst_ready;

	always_comb begin
		emit_req = 1'b0;
		emit_val.out_byte = tlj_pkg::CH_SPACE;
		emit_val.is_error = 1'b0;
		emit_val.last = 1'b0;
		case (state_q)
			S_LEFT, S_GAP, S_RIGHT: begin
				emit_req = (sp_q != '0);
			end
			S_USE: begin
				emit_req = !((kind_q == K_MULTI) && (lrdata == tlj_pkg::CH_SPACE));
				emit_val.out_byte = lrdata;
			end
			S_NL: begin
				emit_req = 1'b1;
				emit_val.out_byte = tlj_pkg::CH_NL;
			end
			S_ERR: begin
				emit_req = 1'b1;
				emit_val.out_byte = tlj_pkg::CH_NUL;
				emit_val.is_error = 1'b1;
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
	end

	assign emit_ok = capped || !pend_v_q || slot_free;
	assign emit_fire = emit_req && emit_ok;
	assign done_ok = !pend_v_q || slot_free;
	assign pop = (state_q == S_DONE) && done_ok;

	assign wwe = (state_q == S_IDLE) && head.valid && !halted_q &&
		(head.cls == tlj_pkg::CLS_TEXT) && (wfill_q < WFW'(WD));
	assign wwaddr = wrap(wbase_q, WAW'(wfill_q));
	assign wraddr = wrap(src_q, k_q);
	assign lwe = ((state_q == S_ADD_SP) && (lwc_q != '0)) || (state_q == S_CP_WR);
	assign lwdata = (state_q == S_CP_WR) ? wrdata : tlj_pkg::CH_SPACE;

	tlj_ram #(.W(8), .DEPTH(WD), .AW(WAW)) u_word_ram (
		.clk(clk),
		.we(wwe),
		.waddr(wwaddr),
		.wdata(head.ch),
		.raddr(wraddr),
		.rdata(wrdata)
	);

	tlj_ram #(.W(8), .DEPTH(MAX_LINE), .AW(LAW)) u_line_ram (
		.clk(clk),
		.we(lwe),
		.waddr(LAW'(lfill_q)),
		.wdata(lwdata),
		.raddr(LAW'(i_q)),
		.rdata(lrdata)
	);

	assign dst_valid = out_v_q;
	assign dst_data = out_q;

	always_ff @(posedge clk) begin
		if (emit_fire && !capped) begin
			pend_q <= emit_val;
		end
		if (pend_v_q && ((emit_fire && !capped) || pop)) begin
			out_q.out_byte <= pend_q.out_byte;
			out_q.is_error <= pend_q.is_error;
			out_q.last <= pop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			add_ret_q <= S_IDLE;
			flush_ret_q <= S_IDLE;
			commit_q <= 1'b0;
			eot_q <= 1'b0;
			halted_q <= 1'b0;
			lfill_q <= '0;
			lwc_q <= '0;
			wfill_q <= '0;
			wbase_q <= '0;
			hyph_q <= '0;
			src_q <= '0;
			len_q <= '0;
			k_q <= '0;
			i_q <= '0;
			kind_q <= K_OVER;
			r_q <= '0;
			quo_q <= '0;
			gaps_q <= '0;
			per_q <= '0;
			extra_q <= '0;
			sp_q <= '0;
			right_q <= '0;
			res_cnt_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit_fire && !capped) begin
				pend_v_q <= 1'b1;
				res_cnt_q <= res_cnt_q + tlj_pkg::RCW'(1);
			end else if (pop) begin
				pend_v_q <= 1'b0;
				res_cnt_q <= '0;
			end
			if (pend_v_q && ((emit_fire && !capped) || pop)) begin
				out_v_q <= 1'b1;
			end else if (dst_ready) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						commit_q <= (head.cls != tlj_pkg::CLS_TEXT);
						eot_q <= (head.cls == tlj_pkg::CLS_EOT);
						if (halted_q) begin
							state_q <= S_DONE;
						end else begin
							if (wwe) begin
								hyph_q[WAW'(wfill_q)] <= (head.ch == tlj_pkg::CH_HYPHEN);
								wfill_q <= wfill_q + WFW'(1);
							end
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					if (wfill_q > WFW'(w_eff)) begin
						if ((w_eff < WAW'(2)) || !found) begin
							flush_ret_q <= S_ERR;
							state_q <= S_FLUSH;
						end else begin
							src_q <= wbase_q;
							len_q <= hp1;
							wbase_q <= wrap(wbase_q, hp1);
							wfill_q <= wfill_q - WFW'(hp1);
							hyph_q <= hyph_q >> hp1;
							add_ret_q <= S_REDUCE;
							state_q <= S_ADD;
						end
					end else begin
						state_q <= commit_q ? S_POST : S_DONE;
					end
				end
				S_POST: begin
					if (wfill_q != '0) begin
						src_q <= wbase_q;
						len_q <= WAW'(wfill_q);
						wfill_q <= '0;
						wbase_q <= '0;
						hyph_q <= '0;
						add_ret_q <= S_TAIL;
						state_q <= S_ADD;
					end else begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					if (eot_q) begin
						flush_ret_q <= S_DONE;
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ADD: begin
					if (fits) begin
						state_q <= S_ADD_SP;
					end else begin
						flush_ret_q <= S_ADD_SP;
						state_q <= S_FLUSH;
					end
				end
				S_ADD_SP: begin
					if (lwc_q != '0) begin
						lfill_q <= lfill_q + WAW'(1);
					end
					lwc_q <= lwc_q + WAW'(1);
					k_q <= '0;
					state_q <= S_CP_RD;
				end
				S_CP_RD: begin
					state_q <= S_CP_WR;
				end
				S_CP_WR: begin
					lfill_q <= lfill_q + WAW'(1);
					k_q <= k_q + WAW'(1);
					state_q <= ((k_q + WAW'(1)) == len_q) ? add_ret_q : S_CP_RD;
				end
				S_FLUSH: begin
					i_q <= '0;
					if (lwc_q == '0) begin
						state_q <= flush_ret_q;
					end else if (lfill_q > w_eff) begin
						kind_q <= K_OVER;
						state_q <= S_RD;
					end else if (lwc_q == WAW'(1)) begin
						kind_q <= K_ONE;
						sp_q <= pad_one_up[WAW:1];
						right_q <= pad_one >> 1;
						state_q <= S_LEFT;
					end else begin
						kind_q <= K_MULTI;
						gaps_q <= gaps_n;
						r_q <= w_eff - (lfill_q - gaps_n);
						quo_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (r_q >= gaps_q) begin
						r_q <= r_q - gaps_q;
						quo_q <= quo_q + WAW'(1);
					end else begin
						per_q <= quo_q;
						extra_q <= r_q;
						state_q <= S_RD;
					end
				end
				S_LEFT: begin
					if (sp_q == '0) begin
						state_q <= S_RD;
					end else if (emit_ok) begin
						sp_q <= sp_q - WAW'(1);
					end
				end
				S_RD: begin
					state_q <= S_USE;
				end
				S_USE, S_GAP: begin
					if ((state_q == S_USE) && !emit_req) begin
						sp_q <= per_q + WAW'(extra_q != '0);
						if (extra_q != '0) begin
							extra_q <= extra_q - WAW'(1);
						end
						state_q <= S_GAP;
					end else if ((state_q == S_GAP) && (sp_q != '0)) begin
						if (emit_ok) begin
							sp_q <= sp_q - WAW'(1);
						end
					end else if (emit_ok) begin
						if (last_ch) begin
							if (kind_q == K_ONE) begin
								sp_q <= right_q;
								state_q <= S_RIGHT;
							end else begin
								state_q <= S_NL;
							end
						end else begin
							i_q <= i_q + WAW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_RIGHT: begin
					if (sp_q == '0) begin
						state_q <= S_NL;
					end else if (emit_ok) begin
						sp_q <= sp_q - WAW'(1);
					end
				end
				S_NL: begin
					if (emit_ok) begin
						lfill_q <= '0;
						lwc_q <= '0;
						state_q <= flush_ret_q;
					end
				end
				S_ERR: begin
					if (emit_ok) begin
						halted_q <= 1'b1;
						wfill_q <= '0;
						wbase_q <= '0;
						hyph_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (done_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/text_line_justifier.sv */
// A separator commits the buffered word, copying it character by character into the line
// buffer. A line flush reads each stored character and sends each output space in turn after
// a setup step; a justified line first divides its spare spaces among the gaps by division.
// The sequencer handles one input byte at a time, walking the registered-read word and line
// buffers one entry at a time; the two-entry input queue can take one more byte meanwhile.
// Reset clears all control state, sets the width to 31 and empties the queue;
// buffer contents are not cleared.
`default_nettype none
`include "text_line_justifier_defines.svh"
module text_line_justifier #(
	parameter int MAX_LINE = tlj_pkg::MAX_LINE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [tlj_pkg::CFG_W-1:0] cfg_wdata,
	input wire logic src_valid,
	output logic src_ready,
	input wire tlj_pkg::in_t src_data,
	output logic dst_valid,
	input wire logic dst_ready,
	output tlj_pkg::out_t dst_data
);
	logic [tlj_pkg::CFG_W-1:0] width_q;
	tlj_pkg::head_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= tlj_pkg::WIDTH_RST;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	tlj_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data(src_data),
		.head(head),
		.pop(pop)
	);

	tlj_back #(.MAX_LINE(MAX_LINE)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.line_width(width_q),
		.head(head),
		.pop(pop),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_data(dst_data)
	);

	`TLJ_ASSERT_IMP(a_full_has_head, !src_ready, head.valid, "queue full without a head word")
	`TLJ_ASSERT_IMP(a_pop_has_head, pop, head.valid, "pop from an empty queue")
	`TLJ_ASSERT_IMP(a_err_is_last, dst_valid && dst_data.is_error, dst_data.last,
		"error result not last of its word")
	`TLJ_ASSERT_IMP(a_err_byte_zero, dst_valid && dst_data.is_error,
		dst_data.out_byte == tlj_pkg::CH_NUL, "error result carries a character")
endmodule
`default_nettype wire
